>>> rtl/ppcp_pkg.sv
// ----------------------------------------------------------------------------
// ppcp_pkg
// Shared types and constants for the polyline closest-point block.
// ----------------------------------------------------------------------------
package ppcp_pkg;

   localparam int MaxVertices = 256;
   localparam int IdxW        = $clog2(MaxVertices);
   localparam int CntW        = IdxW + 1;
   localparam int CoordW      = 16;
   localparam int DiffW       = CoordW + 1;
   localparam int DotW        = 2 * DiffW + 1;
   localparam int QuotW       = 16;
   localparam int DistW       = 33;

   typedef struct packed {
      logic                     starts;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
   } vertex_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_DOT,
      ST_DIV,
      ST_WAIT,
      ST_PROJ,
      ST_DIST,
      ST_SUM,
      ST_CMP,
      ST_DONE
   } state_type;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

endpackage

>>> rtl/ppcp_divider.sv
// ----------------------------------------------------------------------------
// ppcp_divider
// Restoring divider giving floor(num * 2^16 / den) for 0 < num < den.
// ----------------------------------------------------------------------------
module ppcp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ppcp_pkg::DotW-1:0]         num,
   input  logic [ppcp_pkg::DotW-1:0]         den,
   output logic                              done,
   output logic [ppcp_pkg::QuotW-1:0]        quotient
);

   localparam int StepW = $clog2(ppcp_pkg::QuotW + 1);

   logic [ppcp_pkg::DotW:0]        rem_ff, rem_in;
   logic [ppcp_pkg::DotW-1:0]      den_ff, den_in;
   logic [ppcp_pkg::QuotW-1:0]     quo_ff, quo_in;
   logic [StepW-1:0]               cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [ppcp_pkg::DotW+1:0]      trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, 1'b0} - {2'b00, den_ff};
      if (start) begin
         rem_in = {1'b0, num};
         den_in = den;
         cnt_in = StepW'(ppcp_pkg::QuotW);
         run_in = 1'b1;
      end else if (run_ff) begin
         // one quotient bit a cycle
         if (!trial[ppcp_pkg::DotW+1]) begin
            rem_in = trial[ppcp_pkg::DotW:0];
            quo_in = {quo_ff[ppcp_pkg::QuotW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[ppcp_pkg::DotW-1:0], 1'b0};
            quo_in = {quo_ff[ppcp_pkg::QuotW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == StepW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/point_polyline_closest_point.sv
// ----------------------------------------------------------------------------
// point_polyline_closest_point
// Nearest point on a table of polylines to a query point.
// ----------------------------------------------------------------------------
// A word on the req_ channel is taken when start is high and busy is low.
// kind 0 writes a vertex into the slot req_vertex_index; busy stays high for
// the cycle after acceptance while the memory is written, and no result is
// given. kind 1 runs a query over slots 0..vertex_count-1, with vertex_count
// capped at 256, and gives one rsp_ word, shown for one cycle with rsp_valid
// high; the receiver cannot stall it. Each segment steps through RD_A, RD_B,
// DIFF, DOT, DIV, PROJ, DIST, SUM and CMP, and waits in WAIT while the
// bit-serial divider runs when the projection falls strictly inside the
// segment; a segment whose end vertex starts a new polyline stops after DOT.
// rsp_valid is high in the cycle after the query reaches DONE. The vertex
// memory has one read port, so the two ends of each segment are read in
// consecutive cycles.
// csr_write loads vertex_count; write it only while idle.
// Reset clears the controller and vertex_count; the vertex memory holds
// no reset value and must be written before it is queried.
// ----------------------------------------------------------------------------
module point_polyline_closest_point (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [ppcp_pkg::IdxW-1:0]     req_vertex_index,
   input  logic signed [15:0]            req_coord_x,
   input  logic signed [15:0]            req_coord_y,
   input  logic                          req_starts_polyline,
   input  logic                          csr_write,
   input  logic [ppcp_pkg::CntW-1:0]     csr_wdata,
   output logic                          rsp_valid,
   output logic signed [15:0]            rsp_closest_x,
   output logic signed [15:0]            rsp_closest_y,
   output logic [32:0]                   rsp_squared_distance,
   output logic                          rsp_found
);

   localparam int IdxW  = ppcp_pkg::IdxW;
   localparam int CntW  = ppcp_pkg::CntW;
   localparam int DiffW = ppcp_pkg::DiffW;
   localparam int DotW  = ppcp_pkg::DotW;
   localparam int PW    = 42;

   ppcp_pkg::vertex_type mem [ppcp_pkg::MaxVertices];
   ppcp_pkg::vertex_type rd_q;
   logic                 mem_we;
   logic [IdxW-1:0]      mem_addr;
   ppcp_pkg::vertex_type mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      rd_q <= mem[mem_addr];
   end

   ppcp_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [CntW-1:0]     j_ff, j_in;
   logic                wr_ff, wr_in;
   logic [IdxW-1:0]     waddr_ff;
   ppcp_pkg::vertex_type wdata_ff;
   logic signed [15:0]  qx_ff, qy_ff;
   logic signed [15:0]  ax_ff, ay_ff;
   logic                bstart_ff;
   logic signed [DiffW-1:0] ux_ff, uy_ff, wx_ff, wy_ff;
   logic signed [DotW-1:0]    num_ff, den_ff;
   logic [16:0]               t_ff, t_in;
   logic signed [PW-1:0]      px_ff, py_ff;
   logic signed [2*DiffW-1:0] dd0_ff, dd1_ff;
   logic [32:0]               d_ff;
   logic signed [15:0]        cx_ff, cy_ff;
   logic                      found_ff, found_in;
   logic signed [15:0]        best_x_ff, best_y_ff;
   logic [32:0]               best_d_ff;
   logic                      upd;
   logic                      div_start, div_done;
   logic [15:0]               div_q;
   logic                      rsp_v_ff, rsp_v_in;
   logic [CntW-1:0]           n_eff;

   ppcp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign n_eff = (cnt_ff > CntW'(ppcp_pkg::MaxVertices)) ?
                  CntW'(ppcp_pkg::MaxVertices) : cnt_ff;

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      wr_in     = 1'b0;
      found_in  = found_ff;
      t_in      = t_ff;
      rsp_v_in  = 1'b0;
      div_start = 1'b0;
      mem_we    = wr_ff;
      mem_wd    = wdata_ff;
      mem_addr  = wr_ff ? waddr_ff : j_ff[IdxW-1:0];
      upd       = 1'b0;
      cnt_in    = csr_write ? csr_wdata : cnt_ff;
      unique case (state_ff)
         ppcp_pkg::ST_IDLE: begin
            if (start && !wr_ff) begin
               if (req_kind == ppcp_pkg::KIND_WRITE) begin
                  wr_in = 1'b1;
               end else begin
                  found_in = 1'b0;
                  j_in     = CntW'(1);
                  state_in = ppcp_pkg::ST_RD_A;
               end
            end
         end
         ppcp_pkg::ST_RD_A: begin
            // address j-1 is read first, then j
            if (j_ff >= n_eff) begin
               state_in = ppcp_pkg::ST_DONE;
            end else begin
               mem_addr = IdxW'(j_ff - 1'b1);
               state_in = ppcp_pkg::ST_RD_B;
            end
         end
         ppcp_pkg::ST_RD_B: begin
            mem_addr = j_ff[IdxW-1:0];
            state_in = ppcp_pkg::ST_DIFF;
         end
         ppcp_pkg::ST_DIFF: begin
            state_in = ppcp_pkg::ST_DOT;
         end
         ppcp_pkg::ST_DOT: begin
            if (bstart_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = ppcp_pkg::ST_RD_A;
            end else begin
               state_in = ppcp_pkg::ST_DIV;
            end
         end
         ppcp_pkg::ST_DIV: begin
            if (den_ff == '0 || num_ff <= 0) begin
               t_in     = '0;
               state_in = ppcp_pkg::ST_PROJ;
            end else if (num_ff >= den_ff) begin
               t_in     = 17'h10000;
               state_in = ppcp_pkg::ST_PROJ;
            end else begin
               div_start = 1'b1;
               state_in  = ppcp_pkg::ST_WAIT;
            end
         end
         ppcp_pkg::ST_WAIT: begin
            if (div_done) begin
               t_in     = {1'b0, div_q};
               state_in = ppcp_pkg::ST_PROJ;
            end
         end
         ppcp_pkg::ST_PROJ: begin
            state_in = ppcp_pkg::ST_DIST;
         end
         ppcp_pkg::ST_DIST: begin
            state_in = ppcp_pkg::ST_SUM;
         end
         ppcp_pkg::ST_SUM: begin
            state_in = ppcp_pkg::ST_CMP;
         end
         ppcp_pkg::ST_CMP: begin
            // strict compare keeps the earlier segment on a tie
            upd = !found_ff || (d_ff < best_d_ff);
            if (upd) found_in = 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = ppcp_pkg::ST_RD_A;
         end
         ppcp_pkg::ST_DONE: begin
            rsp_v_in = 1'b1;
            state_in = ppcp_pkg::ST_IDLE;
         end
         default: state_in = ppcp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         waddr_ff <= req_vertex_index;
         wdata_ff <= '{starts: req_starts_polyline, x: req_coord_x, y: req_coord_y};
         qx_ff    <= req_coord_x;
         qy_ff    <= req_coord_y;
      end
      if (state_ff == ppcp_pkg::ST_RD_B) begin
         ax_ff <= rd_q.x;
         ay_ff <= rd_q.y;
      end
      if (state_ff == ppcp_pkg::ST_DIFF) begin
         bstart_ff <= rd_q.starts;
         ux_ff     <= DiffW'(rd_q.x) - DiffW'(ax_ff);
         uy_ff     <= DiffW'(rd_q.y) - DiffW'(ay_ff);
         wx_ff     <= DiffW'(qx_ff) - DiffW'(ax_ff);
         wy_ff     <= DiffW'(qy_ff) - DiffW'(ay_ff);
      end
      if (state_ff == ppcp_pkg::ST_DOT) begin
         num_ff <= DotW'(wx_ff * ux_ff) + DotW'(wy_ff * uy_ff);
         den_ff <= DotW'(ux_ff * ux_ff) + DotW'(uy_ff * uy_ff);
      end
      t_ff <= t_in;
      if (state_ff == ppcp_pkg::ST_PROJ) begin
         px_ff <= (PW'(ax_ff) <<< 16) + PW'($signed({1'b0, t_ff}) * ux_ff) + PW'(32768);
         py_ff <= (PW'(ay_ff) <<< 16) + PW'($signed({1'b0, t_ff}) * uy_ff) + PW'(32768);
      end
      if (state_ff == ppcp_pkg::ST_DIST) begin
         cx_ff  <= px_ff[31:16];
         cy_ff  <= py_ff[31:16];
         dd0_ff <= (DiffW'(qx_ff) - DiffW'($signed(px_ff[31:16]))) *
                   (DiffW'(qx_ff) - DiffW'($signed(px_ff[31:16])));
         dd1_ff <= (DiffW'(qy_ff) - DiffW'($signed(py_ff[31:16]))) *
                   (DiffW'(qy_ff) - DiffW'($signed(py_ff[31:16])));
      end
      if (state_ff == ppcp_pkg::ST_SUM) begin
         d_ff <= 33'(dd0_ff) + 33'(dd1_ff);
      end
      if (upd) begin
         best_x_ff <= cx_ff;
         best_y_ff <= cy_ff;
         best_d_ff <= d_ff;
      end
      if (reset) begin
         state_ff     <= ppcp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         j_ff         <= '0;
         wr_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         j_ff         <= j_in;
         wr_ff        <= wr_in;
         found_ff     <= found_in;
         rsp_v_ff     <= rsp_v_in;
      end
   end

   assign busy                 = (state_ff != ppcp_pkg::ST_IDLE) || wr_ff;
   assign rsp_valid            = rsp_v_ff;
   assign rsp_found            = found_ff;
   assign rsp_closest_x        = found_ff ? best_x_ff : '0;
   assign rsp_closest_y        = found_ff ? best_y_ff : '0;
   assign rsp_squared_distance = found_ff ? best_d_ff : '0;

   a_no_start_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppcp_pkg::ST_RD_B) |-> busy)
      else $error("busy low during query");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held longer than one cycle");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ppcp_pkg::ST_DONE))
      else $error("response without query end");
   a_div_only_inside: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (num_ff > 0 && num_ff < den_ff))
      else $error("divider started outside open interval");

endmodule

>>> tb/tb_point_polyline_closest_point.sv
// ----------------------------------------------------------------------------
// tb_point_polyline_closest_point
// Self-checking bench for the polyline closest-point block: loads vertex
// tables, sets vertex_count to values from 0 to 32 and checks every query
// word against an in-bench nearest-point calculation.
// ----------------------------------------------------------------------------
module tb_point_polyline_closest_point;

   localparam int CycleLimit = 1000000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [32:0]        sq_dist;
      logic               found;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = ppcp_pkg::KIND_WRITE;
   logic [7:0]         req_vertex_index = '0;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic               req_starts_polyline = 1'b0;
   logic               csr_write = 1'b0;
   logic [8:0]         csr_wdata = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_closest_x;
   logic signed [15:0] rsp_closest_y;
   logic [32:0]        rsp_squared_distance;
   logic               rsp_found;

   ppcp_pkg::vertex_type table_model [ppcp_pkg::MaxVertices];
   int unsigned count_model;
   answer_type  pending_answers [$];
   int          errors = 0;
   int          cycles = 0;
   int          burst_left = 0;

   point_polyline_closest_point u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_vertex_index(req_vertex_index),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_starts_polyline(req_starts_polyline),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_closest_x(rsp_closest_x),
      .rsp_closest_y(rsp_closest_y), .rsp_squared_distance(rsp_squared_distance),
      .rsp_found(rsp_found)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic answer_type nearest_on_polylines(input logic signed [15:0] qx,
                                                       input logic signed [15:0] qy);
      answer_type  best;
      int unsigned n;
      longint      ax, ay, ux, uy, wx, wy, num, den, t, px, py, dx, dy, d;
      best = '0;
      n = (count_model > ppcp_pkg::MaxVertices) ? ppcp_pkg::MaxVertices : count_model;
      for (int j = 1; j < n; j++) begin
         if (table_model[j].starts) continue;
         ax = $signed(table_model[j-1].x);
         ay = $signed(table_model[j-1].y);
         ux = longint'($signed(table_model[j].x)) - ax;
         uy = longint'($signed(table_model[j].y)) - ay;
         wx = longint'(qx) - ax;
         wy = longint'(qy) - ay;
         num = wx * ux + wy * uy;
         den = ux * ux + uy * uy;
         if (den == 0 || num <= 0) t = 0;
         else if (num >= den) t = 65536;
         else t = (num * 65536) / den;
         // round half up, floor via arithmetic shift
         px = (ax * 65536 + t * ux + 32768) >>> 16;
         py = (ay * 65536 + t * uy + 32768) >>> 16;
         dx = longint'(qx) - px;
         dy = longint'(qy) - py;
         d = dx * dx + dy * dy;
         if (!best.found || d < longint'(best.sq_dist)) begin
            best.found   = 1'b1;
            best.sq_dist = d[32:0];
            best.x       = px[15:0];
            best.y       = py[15:0];
         end
      end
      return best;
   endfunction

   // result checker: the receiver never stalls
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("rsp word with no query outstanding");
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found) begin
               $error("found expected %0d got %0d", want.found, rsp_found);
               errors++;
            end
            if (rsp_closest_x !== want.x) begin
               $error("closest_x expected %0d got %0d", want.x, rsp_closest_x);
               errors++;
            end
            if (rsp_closest_y !== want.y) begin
               $error("closest_y expected %0d got %0d", want.y, rsp_closest_y);
               errors++;
            end
            if (rsp_squared_distance !== want.sq_dist) begin
               $error("squared_distance expected %0d got %0d", want.sq_dist,
                      rsp_squared_distance);
               errors++;
            end
         end
      end
   end

   // called at a falling edge; leaves start high after acceptance
   task automatic send_word(input logic kind, input logic [7:0] idx,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic starts);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
      end
      req_kind            <= kind;
      req_vertex_index    <= idx;
      req_coord_x         <= x;
      req_coord_y         <= y;
      req_starts_polyline <= starts;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      if (kind == ppcp_pkg::KIND_WRITE) begin
         table_model[idx] = '{starts: starts, x: x, y: y};
      end else begin
         pending_answers = {pending_answers, nearest_on_polylines(x, y)};
      end
      burst_left--;
      @(negedge clock);
   endtask

   task automatic put_vertex(input int idx, input int x, input int y, input bit s);
      send_word(ppcp_pkg::KIND_WRITE, idx[7:0], x[15:0], y[15:0], s);
   endtask

   task automatic ask_point(input int x, input int y);
      send_word(ppcp_pkg::KIND_QUERY, 8'($urandom), x[15:0], y[15:0], 1'($urandom));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_answers.size() != 0 || busy) @(negedge clock);
      // a vertex write may still be finishing
      repeat (8) @(negedge clock);
   endtask

   task automatic set_count(input int unsigned value);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= value[8:0];
      @(negedge clock);
      csr_write <= 1'b0;
      count_model = value[8:0];
   endtask

   function automatic int random_coord(input int spread);
      return (spread >= 32768) ? int'($signed(16'($urandom)))
                               : $urandom_range(0, 2 * spread) - spread;
   endfunction

   task automatic test_no_segment;
      put_vertex(0, 1000, -2000, 0);
      set_count(0);
      ask_point(0, 0);
      set_count(1);
      ask_point(-32768, 32767);
   endtask

   task automatic test_directed;
      put_vertex(0, -32768, -32768, 1);
      put_vertex(1, 32767, 32767, 0);
      put_vertex(2, 100, 100, 1);   // zero-length segment
      put_vertex(3, 100, 100, 0);
      put_vertex(4, 0, 4096, 1);    // repeated segment for tie break
      put_vertex(5, 4096, 4096, 0);
      put_vertex(6, 0, 4096, 1);
      put_vertex(7, 4096, 4096, 0);
      set_count(8);
      ask_point(32767, -32768);
      ask_point(-32768, 32767);
      ask_point(-32768, -32768);
      ask_point(32767, 32767);
      ask_point(100, 100);
      ask_point(2048, 8192);
      ask_point(0, 0);
      ask_point(5, -7);
      set_count(2);
      ask_point(32767, -32768);
   endtask

   task automatic test_random_polylines;
      int n, spread, ox, oy;
      for (int phase = 0; phase < 4; phase++) begin
         n = (phase == 0) ? 2 : $urandom_range(3, 8);
         spread = (phase % 3 == 0) ? 32768 : $urandom_range(16, 3000);
         ox = random_coord(20000);
         oy = random_coord(20000);
         for (int s = 0; s < n; s++)
            put_vertex(s, ox + random_coord(spread), oy + random_coord(spread),
                       $urandom_range(0, 4) == 0);
         set_count((phase == 3) ? $urandom_range(0, n) : n);
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 5) == 0)
               put_vertex($urandom_range(0, n - 1), ox + random_coord(spread),
                          oy + random_coord(spread), 1'($urandom));
            else if ($urandom_range(0, 3) == 0)
               ask_point(random_coord(32768), random_coord(32768));
            else
               ask_point(ox + random_coord(2 * spread), oy + random_coord(2 * spread));
         end
      end
   endtask

   task automatic test_long_table;
      for (int s = 0; s < 32; s++)
         put_vertex(s, random_coord(32768), random_coord(32768), $urandom_range(0, 7) == 0);
      set_count(32);
      ask_point(random_coord(32768), random_coord(32768));
      ask_point(32767, 32767);
      ask_point(-32768, -32768);
   endtask

   initial begin
      count_model = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_no_segment();
      test_directed();
      test_random_polylines();
      test_long_table();
      drain();
      repeat (50) @(negedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ppcp_pkg.sv
rtl/ppcp_divider.sv
rtl/point_polyline_closest_point.sv
tb/tb_point_polyline_closest_point.sv
